[hdl/battery_energy_balance_tracker_macros.svh]
// Assertion macros for the battery energy balance tracker.
`ifndef BATTERY_ENERGY_BALANCE_TRACKER_MACROS_SVH
`define BATTERY_ENERGY_BALANCE_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define BEBT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bebt assertion failed");
`define BEBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bebt assertion failed");
`else
`define BEBT_ASSERT_NOW(label, clk, rst, ante, cons)
`define BEBT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/bebt_pkg.sv]
// Shared types and constants of the battery energy balance tracker.
`timescale 1ns / 1ps
`default_nettype none
package bebt_pkg;

  localparam int HOURS_PER_DAY = 24;
  localparam int HOUR_W = $clog2(HOURS_PER_DAY + 1);

  localparam int CHARGE_W = 18;
  localparam int ENERGY_W = 16;
  localparam int SUM_W = 24;
  localparam int DAYS_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 96;

  localparam logic [SUM_W-1:0]  SUM_MAX = '1;
  localparam logic [DAYS_W-1:0] DAYS_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USABLE_CAPACITY   = 2'd0,
    REG_INITIAL_CHARGE    = 2'd1,
    REG_CHARGE_EFFICIENCY = 2'd2,
    REG_DEFICIT_THRESHOLD = 2'd3
  } cfg_reg_t;

  // One classified hour, as handed from front to back.
  typedef struct packed {
    logic [ENERGY_W-1:0] solar;
    logic [ENERGY_W-1:0] load;
    logic [ENERGY_W-1:0] diff;     // surplus or shortfall magnitude
    logic [ENERGY_W-1:0] stored;   // surplus scaled by efficiency
    logic                is_charge;
    logic                new_run;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [DAYS_W-1:0]   short_days;
    logic [SUM_W-1:0]    unmet;
    logic [SUM_W-1:0]    consumption;
    logic [SUM_W-1:0]    production;
    logic [CHARGE_W-1:0] charge;
    logic                month_done;
  } result_t;

  typedef struct packed {
    logic [CHARGE_W-1:0] usable_capacity;
    logic [CHARGE_W-1:0] initial_charge;
    logic [ENERGY_W-1:0] deficit_threshold;
  } back_cfg_t;

endpackage
`default_nettype wire

[hdl/bebt_front.sv]
// Front end: classifies an hour as charge or discharge and scales the surplus.
`timescale 1ns / 1ps
`default_nettype none
module bebt_front (
  input  wire logic [bebt_pkg::ENERGY_W-1:0] solar,
  input  wire logic [bebt_pkg::ENERGY_W-1:0] load,
  input  wire logic                          new_run,
  input  wire logic                          last,
  input  wire logic [bebt_pkg::ENERGY_W-1:0] charge_efficiency,
  output bebt_pkg::item_t                    item
);

  logic                            is_charge;
  logic [bebt_pkg::ENERGY_W-1:0]   diff;
  logic [2*bebt_pkg::ENERGY_W-1:0] product;

  always_comb begin
    is_charge = (solar >= load);
    diff = is_charge ? (solar - load) : (load - solar);
    product = is_charge ? (diff * charge_efficiency) : '0;
    item.solar = solar;
    item.load = load;
    item.diff = diff;
    item.stored = product[2*bebt_pkg::ENERGY_W-1:bebt_pkg::ENERGY_W];
    item.is_charge = is_charge;
    item.new_run = new_run;
    item.last = last;
  end

endmodule
`default_nettype wire

[hdl/bebt_queue.sv]
// Two-entry queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module bebt_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bebt_pkg::item_t push_item,
  input  wire logic            pop,
  output bebt_pkg::item_t      head,
  output logic                 not_empty,
  output logic                 not_full,
  output logic [1:0]           count
);

  bebt_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;

  assign head = entries[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign not_full = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/bebt_back.sv]
// Back end: battery charge, day and month accounting, result register.
`timescale 1ns / 1ps
`default_nettype none
module bebt_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bebt_pkg::back_cfg_t cfg,
  input  wire logic                item_valid,
  input  wire bebt_pkg::item_t     item,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bebt_pkg::result_t        result
);

  logic [bebt_pkg::CHARGE_W-1:0] charge, charge_next;
  logic [bebt_pkg::HOUR_W-1:0]   hour, hour_next;
  logic [bebt_pkg::SUM_W-1:0]    day_unmet, day_unmet_next;
  logic [bebt_pkg::SUM_W-1:0]    prod_sum, prod_sum_next;
  logic [bebt_pkg::SUM_W-1:0]    cons_sum, cons_sum_next;
  logic [bebt_pkg::SUM_W-1:0]    unmet_sum, unmet_sum_next;
  logic [bebt_pkg::DAYS_W-1:0]   day_count, day_count_next;
  bebt_pkg::result_t             result_next;

  logic [bebt_pkg::CHARGE_W-1:0] base, reload_val, taken, diff_ext;
  logic [bebt_pkg::CHARGE_W:0]   charge_sum;
  logic [bebt_pkg::SUM_W:0]      prod_add, cons_add, unmet_add, month_unmet_add;
  logic [bebt_pkg::SUM_W-1:0]    day_unmet_upd, prod_upd, cons_upd, unmet_upd;
  logic [bebt_pkg::DAYS_W-1:0]   count_upd;
  logic [bebt_pkg::HOUR_W:0]     hour_inc;
  logic                          day_end, deficit_day;

  assign pop = item_valid && (!out_valid || out_ready);

  always_comb begin
    reload_val = (cfg.initial_charge < cfg.usable_capacity) ?
                 cfg.initial_charge : cfg.usable_capacity;
    base = item.new_run ? reload_val : charge;
    diff_ext = bebt_pkg::CHARGE_W'(item.diff);
    charge_sum = {1'b0, base} + (bebt_pkg::CHARGE_W + 1)'(item.stored);
    taken = (diff_ext < base) ? diff_ext : base;

    prod_add = {1'b0, prod_sum} + (bebt_pkg::SUM_W + 1)'(item.solar);
    cons_add = {1'b0, cons_sum} + (bebt_pkg::SUM_W + 1)'(item.load);
    prod_upd = prod_add[bebt_pkg::SUM_W] ? bebt_pkg::SUM_MAX : prod_add[bebt_pkg::SUM_W-1:0];
    cons_upd = cons_add[bebt_pkg::SUM_W] ? bebt_pkg::SUM_MAX : cons_add[bebt_pkg::SUM_W-1:0];

    day_unmet_upd = day_unmet;
    unmet_add = '0;
    if (item.is_charge) begin
      charge_next = (charge_sum < {1'b0, cfg.usable_capacity}) ?
                    charge_sum[bebt_pkg::CHARGE_W-1:0] : cfg.usable_capacity;
    end else begin
      charge_next = base - taken;
      unmet_add = {1'b0, day_unmet} + (bebt_pkg::SUM_W + 1)'(diff_ext - taken);
      day_unmet_upd = unmet_add[bebt_pkg::SUM_W] ? bebt_pkg::SUM_MAX :
                      unmet_add[bebt_pkg::SUM_W-1:0];
    end

    hour_inc = {1'b0, hour} + (bebt_pkg::HOUR_W + 1)'(1);
    day_end = item.last || (hour_inc >= (bebt_pkg::HOUR_W + 1)'(bebt_pkg::HOURS_PER_DAY));
    deficit_day = day_end &&
                  (day_unmet_upd > bebt_pkg::SUM_W'(cfg.deficit_threshold));

    month_unmet_add = {1'b0, unmet_sum} + {1'b0, day_unmet_upd};
    unmet_upd = unmet_sum;
    count_upd = day_count;
    if (deficit_day) begin
      unmet_upd = month_unmet_add[bebt_pkg::SUM_W] ? bebt_pkg::SUM_MAX :
                  month_unmet_add[bebt_pkg::SUM_W-1:0];
      count_upd = (day_count == bebt_pkg::DAYS_MAX) ? day_count : day_count + 1'b1;
    end

    hour_next = day_end ? '0 : hour_inc[bebt_pkg::HOUR_W-1:0];
    day_unmet_next = day_end ? '0 : day_unmet_upd;

    result_next.charge = charge_next;
    result_next.month_done = item.last;
    if (item.last) begin
      result_next.production = prod_upd;
      result_next.consumption = cons_upd;
      result_next.unmet = unmet_upd;
      result_next.short_days = count_upd;
      prod_sum_next = '0;
      cons_sum_next = '0;
      unmet_sum_next = '0;
      day_count_next = '0;
    end else begin
      result_next.production = '0;
      result_next.consumption = '0;
      result_next.unmet = '0;
      result_next.short_days = '0;
      prod_sum_next = prod_upd;
      cons_sum_next = cons_upd;
      unmet_sum_next = unmet_upd;
      day_count_next = count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charge <= '0;
      hour <= '0;
      day_unmet <= '0;
      prod_sum <= '0;
      cons_sum <= '0;
      unmet_sum <= '0;
      day_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        charge <= charge_next;
        hour <= hour_next;
        day_unmet <= day_unmet_next;
        prod_sum <= prod_sum_next;
        cons_sum <= cons_sum_next;
        unmet_sum <= unmet_sum_next;
        day_count <= day_count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

[hdl/battery_energy_balance_tracker.sv]
// Top level of the battery energy balance tracker.
// Takes one hour of solar and load energy per request and returns one result
// per request: the battery charge after that hour and, on the last hour of a
// month, the month totals (zero otherwise). One request can be accepted every
// cycle while the queue is not full. A result passes through the queue register
// and the output register before it is offered; the surplus scaling is
// combinational ahead of the queue. A two-entry queue between the stages and
// the output register let either side stall on its own.
// Configuration is to be written by the user only while no request is in
// flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_energy_balance_tracker_macros.svh"
module battery_energy_balance_tracker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [15:0] solar_energy, [31:16] load_energy
  input  wire logic [bebt_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic                              s_tlast,   // last_of_month
  input  wire logic                              s_tuser,   // [0] new_run
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [17:0] charge_now, [41:18] month_production, [65:42] month_consumption,
  // [89:66] month_unmet_energy, [94:90] month deficit-day count, [95] zero
  output logic [bebt_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic                                   m_tuser,   // [0] month_done
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bebt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bebt_pkg::CHARGE_W-1:0]     cfg_data
);

  logic [bebt_pkg::CHARGE_W-1:0] usable_capacity;
  logic [bebt_pkg::CHARGE_W-1:0] initial_charge;
  logic [bebt_pkg::ENERGY_W-1:0] charge_efficiency;
  logic [bebt_pkg::ENERGY_W-1:0] deficit_threshold;

  bebt_pkg::item_t     front_item, q_head;
  bebt_pkg::back_cfg_t back_cfg;
  bebt_pkg::result_t   result;
  logic                push, pop, q_not_empty, q_not_full;
  logic [1:0]          q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_capacity <= bebt_pkg::CHARGE_W'(8000);
      initial_charge <= bebt_pkg::CHARGE_W'(4000);
      charge_efficiency <= bebt_pkg::ENERGY_W'(63570);
      deficit_threshold <= bebt_pkg::ENERGY_W'(50);
    end else if (cfg_valid && cfg_ready) begin
      unique case (bebt_pkg::cfg_reg_t'(cfg_index))
        bebt_pkg::REG_USABLE_CAPACITY:   usable_capacity <= cfg_data;
        bebt_pkg::REG_INITIAL_CHARGE:    initial_charge <= cfg_data;
        bebt_pkg::REG_CHARGE_EFFICIENCY:
          charge_efficiency <= cfg_data[bebt_pkg::ENERGY_W-1:0];
        bebt_pkg::REG_DEFICIT_THRESHOLD:
          deficit_threshold <= cfg_data[bebt_pkg::ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.usable_capacity = usable_capacity;
  assign back_cfg.initial_charge = initial_charge;
  assign back_cfg.deficit_threshold = deficit_threshold;

  assign s_tready = q_not_full;
  assign push = s_tvalid && s_tready;

  bebt_front u_front (
    .solar             (s_tdata[15:0]),
    .load              (s_tdata[31:16]),
    .new_run           (s_tuser),
    .last              (s_tlast),
    .charge_efficiency (charge_efficiency),
    .item              (front_item)
  );

  bebt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full),
    .count     (q_count)
  );

  bebt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (back_cfg),
    .item_valid (q_not_empty),
    .item       (q_head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result     (result)
  );

  assign m_tuser = result.month_done;
  assign m_tdata = {1'b0, result.short_days, result.unmet, result.consumption,
                    result.production, result.charge};

  `BEBT_ASSERT_NOW(a_month_fields_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[94:18] == '0)
  `BEBT_ASSERT_NOW(a_full_blocks_input, clk, rst, q_count == 2'd2, !s_tready)
  `BEBT_ASSERT_NOW(a_pop_needs_item, clk, rst, pop, q_count != 2'd0)
  `BEBT_ASSERT_NEXT(a_pop_gives_result, clk, rst, pop, m_tvalid)

endmodule
`default_nettype wire
